/* rtl/filename_to_sixbit_words_top_assert.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef FILENAME_TO_SIXBIT_WORDS_TOP_ASSERT_SVH
`define FILENAME_TO_SIXBIT_WORDS_TOP_ASSERT_SVH

// property under clock with reset disable
`define FSW_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fsw assertion failed");

// antecedent implies consequent in the next cycle
`define FSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `FSW_ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/fsw_pkg.sv */
// shared constants, types and character conversion for the file name packer
// no dependencies
package fsw_pkg;

    localparam int unsigned CHAR_W = 7;
    localparam int unsigned WORD_W = 36;
    localparam int unsigned SIX_W  = 6;
    localparam int unsigned SLOTS  = 6;
    localparam int unsigned COUNT_W = 3;

    localparam logic [WORD_W-1:0] C_DEFAULT_DEVICE    = 36'o446353000000;
    localparam logic [WORD_W-1:0] C_DEFAULT_SECOND    = 36'o360000000000;
    localparam logic [WORD_W-1:0] C_DEFAULT_DIRECTORY = 36'o166445556016;

    localparam logic [CHAR_W-1:0] C_NUL       = 7'o000;
    localparam logic [CHAR_W-1:0] C_SPACE     = 7'o040;
    localparam logic [CHAR_W-1:0] C_COLON     = 7'o072;
    localparam logic [CHAR_W-1:0] C_SEMICOLON = 7'o073;
    localparam logic [CHAR_W-1:0] C_QUOTE     = 7'o021;
    localparam logic [CHAR_W-1:0] C_LOWER_MIN = 7'o140;
    localparam logic [CHAR_W-1:0] C_LOWER_OFS = 7'o100;
    localparam logic [CHAR_W-1:0] C_UPPER_OFS = 7'o040;

    typedef struct packed {
        logic [WORD_W-1:0] device_word;
        logic [WORD_W-1:0] first_name_word;
        logic [WORD_W-1:0] second_name_word;
        logic [WORD_W-1:0] directory_word;
    } t_words;

    function automatic logic [SIX_W-1:0] f_sixbit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        diff = (c >= C_LOWER_MIN) ? (c - C_LOWER_OFS) : (c - C_UPPER_OFS);
        return diff[SIX_W-1:0];
    endfunction

endpackage

/* rtl/fsw_if.sv */
// valid/ready channel interfaces for characters in and packed words out
// depends on fsw_pkg
interface fsw_char_if;
    import fsw_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface fsw_words_if;
    import fsw_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] device_word;
    logic [WORD_W-1:0] first_name_word;
    logic [WORD_W-1:0] second_name_word;
    logic [WORD_W-1:0] directory_word;

    modport source (output valid, output device_word, output first_name_word,
                    output second_name_word, output directory_word, input ready);
    modport sink   (input valid, input device_word, input first_name_word,
                    input second_name_word, input directory_word, output ready);
endinterface

/* rtl/fsw_core.sv */
// held words, syllable accumulator and per-character update
// depends on fsw_pkg
module fsw_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [fsw_pkg::CHAR_W-1:0]   i_char_code,
    output fsw_pkg::t_words              o_words
);
    import fsw_pkg::*;

    logic [WORD_W-1:0]  r_device, r_first, r_second, r_directory, r_acc;
    logic [COUNT_W-1:0] r_count;
    logic               r_quote;

    logic [WORD_W-1:0]  n_device, n_first, n_second, n_directory, n_acc;
    logic [COUNT_W-1:0] n_count;
    logic               n_quote;

    logic [SIX_W-1:0]   sixbit;
    logic [WORD_W-1:0]  acc_packed;
    logic [COUNT_W-1:0] count_packed;
    logic               commit, to_first;
    logic [WORD_W-1:0]  first_commit, second_commit;

    assign sixbit = f_sixbit(i_char_code);

    always_comb begin
        acc_packed   = r_acc;
        count_packed = r_count;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_count == COUNT_W'(i)) begin
                acc_packed[WORD_W-SIX_W*(i+1) +: SIX_W] = sixbit;
                count_packed = COUNT_W'(i + 1);
            end
        end
    end

    assign commit = !r_quote && ((i_char_code == C_NUL) || (i_char_code == C_SPACE))
                    && (r_acc != '0);
    assign to_first = (r_first == '0);
    assign first_commit  = (commit && to_first)  ? r_acc : r_first;
    assign second_commit = (commit && !to_first) ? r_acc : r_second;

    assign o_words.device_word      = r_device;
    assign o_words.first_name_word  = first_commit;
    assign o_words.second_name_word = second_commit;
    assign o_words.directory_word   = r_directory;

    always_comb begin
        n_device    = r_device;
        n_first     = r_first;
        n_second    = r_second;
        n_directory = r_directory;
        n_acc       = r_acc;
        n_count     = r_count;
        n_quote     = r_quote;
        if (i_step) begin
            if (i_char_code == C_NUL) begin
                n_device    = C_DEFAULT_DEVICE;
                n_first     = '0;
                n_second    = C_DEFAULT_SECOND;
                n_directory = C_DEFAULT_DIRECTORY;
                n_acc       = '0;
                n_count     = '0;
                n_quote     = 1'b0;
            end else if (r_quote) begin
                n_quote = 1'b0;
                n_acc   = acc_packed;
                n_count = count_packed;
            end else begin
                case (i_char_code)
                    C_COLON: begin
                        n_device = r_acc;
                        n_acc    = '0;
                        n_count  = '0;
                    end
                    C_SEMICOLON: begin
                        n_directory = r_acc;
                        n_acc       = '0;
                        n_count     = '0;
                    end
                    C_SPACE: begin
                        n_first  = first_commit;
                        n_second = second_commit;
                        n_acc    = '0;
                        n_count  = '0;
                    end
                    C_QUOTE: begin
                        n_quote = 1'b1;
                    end
                    default: begin
                        n_acc   = acc_packed;
                        n_count = count_packed;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device    <= C_DEFAULT_DEVICE;
            r_first     <= '0;
            r_second    <= C_DEFAULT_SECOND;
            r_directory <= C_DEFAULT_DIRECTORY;
            r_acc       <= '0;
            r_count     <= '0;
            r_quote     <= 1'b0;
        end else begin
            r_device    <= n_device;
            r_first     <= n_first;
            r_second    <= n_second;
            r_directory <= n_directory;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_quote     <= n_quote;
        end
    end

endmodule

/* rtl/filename_to_sixbit_words_top.sv */
// channel    | dir | payload                                   | fires
// i_char     | in  | char_code[6:0]                            | every character
// o_words    | out | device, first name, second name, dir [35:0] | on each NUL
//
// one character per cycle while no NUL stalls; a character is registered, decoded and folded
// into the held words as it leaves the input register, and a NUL loads the output register
// the output register lets the next characters in while a result waits;
// only a NUL at the input register stalls behind an untaken result
// synchronous active-low reset loads the default words
// depends on fsw_pkg, fsw_if, fsw_core
module filename_to_sixbit_words_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsw_char_if.sink    i_char,
    fsw_words_if.source o_words
);
    import fsw_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    t_words            r_out_words;

    logic   in_emit, out_free, proc, accept;
    t_words core_words;

    assign in_emit  = (r_in_char == C_NUL);
    assign out_free = !r_out_valid || o_words.ready;
    assign proc     = r_in_valid && (!in_emit || out_free);
    assign accept   = i_char.valid && i_char.ready;

    assign i_char.ready = !r_in_valid || proc;

    fsw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (proc),
        .i_char_code (r_in_char),
        .o_words     (core_words)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc && in_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_words.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char.char_code;
        end
        if (proc && in_emit) begin
            r_out_words <= core_words;
        end
    end

    assign o_words.valid            = r_out_valid;
    assign o_words.device_word      = r_out_words.device_word;
    assign o_words.first_name_word  = r_out_words.first_name_word;
    assign o_words.second_name_word = r_out_words.second_name_word;
    assign o_words.directory_word   = r_out_words.directory_word;

endmodule

/* rtl/fsw_checker.sv */
// port-level checks for the file name packer, bound to the top level
// depends on filename_to_sixbit_words_top_assert.svh
`include "filename_to_sixbit_words_top_assert.svh"

module fsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [35:0] i_out_device
);

    `FSW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `FSW_ASSERT_PROP(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)
    `FSW_ASSERT_PROP(a_no_word_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_out_valid)
    `FSW_ASSERT_NEXT(a_stalled_device_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_device) && (i_in_valid || !i_in_valid))

endmodule

bind filename_to_sixbit_words_top fsw_checker u_fsw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_char.valid),
    .i_in_ready   (i_char.ready),
    .i_out_valid  (o_words.valid),
    .i_out_ready  (o_words.ready),
    .i_out_device (o_words.device_word)
);

/* tb/sv/tb_filename_to_sixbit_words_top.sv */
// testbench for filename_to_sixbit_words_top: drives characters, predicts the four packed words
// depends on fsw_pkg, fsw_if and the rtl of filename_to_sixbit_words_top
`timescale 1ns / 1ps

module tb_filename_to_sixbit_words_top;
    import fsw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsw_char_if  char_ch();
    fsw_words_if words_ch();

    filename_to_sixbit_words_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_words (words_ch)
    );

    always #6 i_clk = ~i_clk;

    // packer state as predicted
    logic [WORD_W-1:0] device_pred;
    logic [WORD_W-1:0] first_pred;
    logic [WORD_W-1:0] second_pred;
    logic [WORD_W-1:0] directory_pred;
    logic [WORD_W-1:0] syllable_pred;
    int                syllable_len;
    logic              quote_armed;

    t_words words_expected[$];

    int errors        = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int burst_left    = 0;
    int chars_sent    = 0;

    function automatic logic [SIX_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        if (c >= 7'o140) begin
            diff = c - 7'o100;
        end else begin
            diff = c - 7'o040;
        end
        return diff[SIX_W-1:0];
    endfunction

    task automatic reload_defaults();
        device_pred    = C_DEFAULT_DEVICE;
        first_pred     = '0;
        second_pred    = C_DEFAULT_SECOND;
        directory_pred = C_DEFAULT_DIRECTORY;
        syllable_pred  = '0;
        syllable_len   = 0;
        quote_armed    = 1'b0;
    endtask

    task automatic append_char(input logic [CHAR_W-1:0] c);
        if (syllable_len < SLOTS) begin
            syllable_pred[WORD_W-1-SIX_W*syllable_len -: SIX_W] = fold_char(c);
            syllable_len++;
        end
    endtask

    task automatic end_name();
        t_words w;
        w.device_word      = device_pred;
        w.first_name_word  = first_pred;
        w.second_name_word = second_pred;
        w.directory_word   = directory_pred;
        words_expected.push_back(w);
        reload_defaults();
    endtask

    task automatic predict_char(input logic [CHAR_W-1:0] c);
        if (quote_armed) begin
            quote_armed = 1'b0;
            if (c == C_NUL) begin
                end_name();
            end else begin
                append_char(c);
            end
        end else begin
            case (c)
                C_COLON: begin
                    device_pred   = syllable_pred;
                    syllable_pred = '0;
                    syllable_len  = 0;
                end
                C_SEMICOLON: begin
                    directory_pred = syllable_pred;
                    syllable_pred  = '0;
                    syllable_len   = 0;
                end
                C_NUL, C_SPACE: begin
                    if (syllable_pred != '0) begin
                        if (first_pred == '0) begin
                            first_pred = syllable_pred;
                        end else begin
                            second_pred = syllable_pred;
                        end
                    end
                    syllable_pred = '0;
                    syllable_len  = 0;
                    if (c == C_NUL) begin
                        end_name();
                    end
                end
                C_QUOTE: begin
                    quote_armed = 1'b1;
                end
                default: begin
                    append_char(c);
                end
            endcase
        end
    endtask

    // sender in bursts with gaps between them
    task automatic send_char(input logic [CHAR_W-1:0] c);
        if (burst_left == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 80);
            end else begin
                burst_left = $urandom_range(1, 24);
            end
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        @(posedge i_clk);
        while (!(char_ch.valid && char_ch.ready)) @(posedge i_clk);
        burst_left--;
        chars_sent++;
        predict_char(c);
    endtask

    task automatic send_text(input string s);
        byte ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            send_char(ch[CHAR_W-1:0]);
        end
    endtask

    function automatic logic [CHAR_W-1:0] name_char();
        if ($urandom_range(0, 4) == 0) begin
            return CHAR_W'($urandom_range(1, 31));
        end
        return CHAR_W'($urandom_range(33, 126));
    endfunction

    task automatic send_random_name();
        int syllables;
        int len;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                send_char(CHAR_W'($urandom_range(0, 127)));
            end
            send_char(C_NUL);
            return;
        end
        syllables = $urandom_range(0, 4);
        for (int k = 0; k < syllables; k++) begin
            len = $urandom_range(0, 8);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_char(C_QUOTE);
                    send_char(CHAR_W'($urandom_range(0, 127)));
                end else begin
                    send_char(name_char());
                end
            end
            pick = $urandom_range(0, 3);
            case (pick)
                0:       send_char(C_COLON);
                1:       send_char(C_SEMICOLON);
                default: send_char(C_SPACE);
            endcase
        end
        len = $urandom_range(0, 7);
        for (int j = 0; j < len; j++) begin
            send_char(name_char());
        end
        if ($urandom_range(0, 14) == 0) begin
            send_char(C_QUOTE);
        end
        send_char(C_NUL);
    endtask

    task automatic test_default_words();
        send_char(C_NUL);
    endtask

    // device, directory, case folding, long syllable, empty syllable, second name
    task automatic test_fields_and_folding();
        send_text("dK:x;ABCDEFGH  ");
        send_char(7'h7f);
        send_char(7'o001);
        send_char(C_NUL);
    endtask

    // quoted colon, quoted quote, quote before end drops the syllable
    task automatic test_quoting();
        send_char(C_QUOTE);
        send_char(C_COLON);
        send_char(C_QUOTE);
        send_char(C_QUOTE);
        send_char(C_SPACE);
        send_text("q");
        send_char(C_QUOTE);
        send_char(C_NUL);
    endtask

    // receiver holds off while names keep coming so the input stalls
    task automatic test_output_backpressure();
        hold_requests++;
        repeat (5) send_random_name();
    endtask

    task automatic test_random_names();
        int chars_start;
        chars_start = chars_sent;
        while ((chars_sent - chars_start) < 340) begin
            send_random_name();
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (!i_rst_n) begin
            words_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            words_ch.ready <= 1'b0;
        end else begin
            case ((cycle_count / 128) % 4)
                0:       words_ch.ready <= 1'b1;
                1:       words_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       words_ch.ready <= ($urandom_range(0, 3) == 0);
                default: words_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic check_field(input string field, input logic [WORD_W-1:0] exp_w,
                               input logic [WORD_W-1:0] act_w);
        if (act_w !== exp_w) begin
            $display("%0t %s mismatch: expected %o actual %o", $time, field, exp_w, act_w);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_words w;
        if (i_rst_n && words_ch.valid && words_ch.ready) begin
            if (words_expected.size() == 0) begin
                $display("%0t unexpected word: expected none actual %o %o %o %o", $time,
                         words_ch.device_word, words_ch.first_name_word,
                         words_ch.second_name_word, words_ch.directory_word);
                errors++;
            end else begin
                w = words_expected.pop_front();
                check_field("device", w.device_word, words_ch.device_word);
                check_field("first name", w.first_name_word, words_ch.first_name_word);
                check_field("second name", w.second_name_word, words_ch.second_name_word);
                check_field("directory", w.directory_word, words_ch.directory_word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_filename_to_sixbit_words_top NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        reload_defaults();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_words();
        test_fields_and_folding();
        test_quoting();
        test_output_backpressure();
        test_random_names();

        char_ch.valid <= 1'b0;
        while (words_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (errors == 0 && words_expected.size() == 0) begin
            $display("tb_filename_to_sixbit_words_top OK");
        end else begin
            $display("tb_filename_to_sixbit_words_top NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fsw_pkg.sv
rtl/fsw_if.sv
rtl/fsw_core.sv
rtl/filename_to_sixbit_words_top.sv
rtl/fsw_checker.sv
tb/sv/tb_filename_to_sixbit_words_top.sv
